/* rtl/ethc_pkg.sv */
// Shared constants, codes and transaction types of the dual receive buffer Ethernet controller.
package ethc_pkg;

   localparam int BUFFER_BYTES = 2048;   // power of two, 256 to 2048
   localparam int BUF_AW       = $clog2(BUFFER_BYTES);
   localparam int RX_AW        = BUF_AW + 1;
   localparam int CNT_W        = BUF_AW;

   localparam logic [47:0] ROM_RESET = 48'd11707042246;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_RX    = 2'd2;
   localparam logic [1:0] MODE_FETCH = 2'd3;

   localparam logic [1:0] RX_NONE = 2'd0;
   localparam logic [1:0] RX_A    = 2'd1;
   localparam logic [1:0] RX_B    = 2'd2;
   localparam logic [1:0] RX_DROP = 2'd3;

   localparam logic [1:0] TGT_NONE    = 2'd0;
   localparam logic [1:0] TGT_A       = 2'd1;
   localparam logic [1:0] TGT_B       = 2'd2;
   localparam logic [1:0] TGT_DISCARD = 2'd3;

   localparam int ST_RESET  = 0;
   localparam int ST_RBBA   = 2;
   localparam int ST_AMSW   = 3;
   localparam int ST_JAM    = 4;
   localparam int ST_TBSW   = 5;
   localparam int ST_ABSW   = 6;
   localparam int ST_BBSW   = 7;
   localparam int ST_TINTEN = 13;
   localparam int ST_AINTEN = 14;
   localparam int ST_BINTEN = 15;

   localparam logic [15:0] HDR_NOT_OURS  = 16'h1000;
   localparam logic [15:0] HDR_BROADCAST = 16'h4000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
      logic [7:0]  rx_byte;
      logic        rx_last;
      logic [10:0] fetch_offset;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        bad_address;
      logic        interrupt;
      logic        tx_start;
      logic [10:0] tx_offset;
      logic [11:0] tx_length;
      logic [7:0]  tx_data;
      logic [1:0]  rx_result;
   } rsp_item_type;

endpackage

/* rtl/ethc_if.sv */
// Valid/ready channel interfaces for bus, frame and fetch transactions and their results.
interface ethc_req_if import ethc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ethc_rsp_if import ethc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ethc_ram.sv */
// Generic simple dual-port RAM with registered read.
module ethc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/ethernet_controller_dual_rx_buffer_core.sv */
// Ethernet controller core: register window, station RAM, transmit and two receive buffers.
// Usage:
//   req_ch carries one transaction: a bus read or write, a received frame byte or a
//   transmit byte fetch. rsp_ch returns exactly one result per transaction, in order.
//   csr_wr_en/csr_wr_data load the 48-bit address shown in the ROM window; write it
//   only while no transaction is outstanding.
// Steps per transaction, from acceptance to result valid (receiver ready):
//   status, ROM, ignored or unmapped accesses and plain buffer writes: straight to output;
//   station and buffer reads and fetches: one registered RAM read;
//   a transmit handover: two offset reads, six station byte copies;
//   the last byte of a frame: six station compares, two header writes unless dropped.
//   One transaction is in work at a time; the next can be accepted in the cycle after the
//   previous one finishes, even while its result still waits in the output register.
// Reset clears status, frame tracking and the output valid flag; the ROM address
//   returns to its default. Buffer and station RAM contents are undefined until
//   written.
// When the receiver stalls, the finished result is held in the output register and
//   the following transaction waits to complete until that register frees.
module ethernet_controller_dual_rx_buffer_core import ethc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ethc_req_if.sink          req_ch,
   ethc_rsp_if.source        rsp_ch,
   input  logic              csr_wr_en,
   input  logic [47:0]       csr_wr_data
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RD   = 8'b0000_0010,
      S_TXH0 = 8'b0000_0100,
      S_TXH1 = 8'b0000_1000,
      S_COPY = 8'b0001_0000,
      S_CMP  = 8'b0010_0000,
      S_HDR  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   localparam logic [1:0] SEL_STN = 2'd0;
   localparam logic [1:0] SEL_TX  = 2'd1;
   localparam logic [1:0] SEL_RX  = 2'd2;

   state_type            state_ff, state_in;
   req_item_type         item_ff, item_in;
   rsp_item_type         res_ff, res_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          status_ff, status_in;
   logic [47:0]          rom_ff;
   logic [1:0]           tgt_ff, tgt_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [5:0][7:0]      dest_ff, dest_in;
   logic [2:0]           idx_ff, idx_in;
   logic                 ours_ff, ours_in;
   logic [BUF_AW-1:0]    off_ff, off_in;
   logic [2:0]           offhi_ff, offhi_in;
   logic [1:0]           sel_ff, sel_in;

   logic                 stn_we;
   logic [2:0]           stn_wa, stn_ra;
   logic [7:0]           stn_wd, stn_rd;
   logic                 tx_we;
   logic [BUF_AW-1:0]    tx_wa, tx_ra;
   logic [7:0]           tx_wd, tx_rd;
   logic                 rx_we;
   logic [RX_AW-1:0]     rx_wa, rx_ra;
   logic [7:0]           rx_wd, rx_rd;

   ethc_ram #(.Width(8), .Depth(8)) u_stn_ram (
      .clock(clock), .wr_en(stn_we), .wr_addr(stn_wa), .wr_data(stn_wd),
      .rd_addr(stn_ra), .rd_data(stn_rd));
   ethc_ram #(.Width(8), .Depth(BUFFER_BYTES)) u_tx_ram (
      .clock(clock), .wr_en(tx_we), .wr_addr(tx_wa), .wr_data(tx_wd),
      .rd_addr(tx_ra), .rd_data(tx_rd));
   ethc_ram #(.Width(8), .Depth(2 * BUFFER_BYTES)) u_rx_ram (
      .clock(clock), .wr_en(rx_we), .wr_addr(rx_wa), .wr_data(rx_wd),
      .rd_addr(rx_ra), .rd_data(rx_rd));

   req_item_type      rq;
   logic [15:0]       a;
   logic [15:0]       merged, st_tmp;
   logic [1:0]        t_new;
   logic [CNT_W-1:0]  c_cur;
   logic [5:0][7:0]   d_cur;
   logic              ours_now, bcast, drop;
   logic [15:0]       hdr;
   logic [3:0]        pa;
   logic [10:0]       off11;
   logic [BUF_AW-1:0] off_new;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      status_in    = status_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      dest_in      = dest_ff;
      idx_in       = idx_ff;
      ours_in      = ours_ff;
      off_in       = off_ff;
      offhi_in     = offhi_ff;
      sel_in       = sel_ff;
      stn_we = 1'b0; stn_wa = '0; stn_wd = '0; stn_ra = '0;
      tx_we  = 1'b0; tx_wa  = '0; tx_wd  = '0; tx_ra  = '0;
      rx_we  = 1'b0; rx_wa  = '0; rx_wd  = '0; rx_ra  = '0;
      rq       = req_ch.data;
      a        = rq.bus_address;
      merged   = status_ff;
      st_tmp   = status_ff;
      t_new    = TGT_DISCARD;
      c_cur    = cnt_ff;
      d_cur    = dest_ff;
      ours_now = ours_ff;
      bcast    = 1'b0;
      drop     = 1'b0;
      hdr      = '0;
      pa       = status_ff[11:8];
      off11    = '0;
      off_new  = '0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               item_in  = rq;
               res_in   = '0;
               state_in = S_DONE;
               case (rq.mode)
                  MODE_READ: begin
                     if (a[15:13] != 3'd0) begin
                        res_in.bad_address = 1'b1;
                        res_in.read_data   = 8'hFF;
                     end else if (a[12:10] == 3'b000) begin
                        case (a[1:0])
                           2'd0:    res_in.read_data = status_ff[7:0];
                           2'd1:    res_in.read_data = status_ff[15:8];
                           default: res_in.read_data = 8'h00;
                        endcase
                     end else if (a[12:9] == 4'b0010) begin
                        case (a[2:0])
                           3'd0:    res_in.read_data = rom_ff[47:40];
                           3'd1:    res_in.read_data = rom_ff[39:32];
                           3'd2:    res_in.read_data = rom_ff[31:24];
                           3'd3:    res_in.read_data = rom_ff[23:16];
                           3'd4:    res_in.read_data = rom_ff[15:8];
                           3'd5:    res_in.read_data = rom_ff[7:0];
                           default: res_in.read_data = 8'h00;
                        endcase
                     end else if (a[12:9] == 4'b0011) begin
                        stn_ra   = a[2:0];
                        sel_in   = SEL_STN;
                        state_in = S_RD;
                     end else if (a[12:11] == 2'b01) begin
                        tx_ra    = a[BUF_AW-1:0];
                        sel_in   = SEL_TX;
                        state_in = S_RD;
                     end else begin
                        rx_ra    = {a[11], a[BUF_AW-1:0]};
                        sel_in   = SEL_RX;
                        state_in = S_RD;
                     end
                  end
                  MODE_WRITE: begin
                     if (a[15:13] != 3'd0) begin
                        res_in.bad_address = 1'b1;
                     end else if (a[12:10] == 3'b000) begin
                        case (a[1:0])
                           2'd0:    merged = {status_ff[15:8], rq.write_data};
                           2'd1:    merged = {rq.write_data, status_ff[7:0]};
                           default: merged = status_ff;
                        endcase
                        if (merged[ST_RESET]) begin
                           status_in = '0;
                        end else begin
                           if (merged[ST_AMSW]) begin
                              st_tmp[ST_AMSW] = 1'b1;
                           end
                           st_tmp = {merged[15:8], st_tmp[7:0]};
                           st_tmp[ST_TBSW] = 1'b0;
                           st_tmp[ST_JAM]  = 1'b0;
                           st_tmp[ST_RBBA] = 1'b0;
                           st_tmp[ST_ABSW] = 1'b1;
                           st_tmp[ST_BBSW] = 1'b1;
                           status_in = st_tmp;
                           if (merged[ST_TBSW] && !status_ff[ST_TBSW]) begin
                              // handover: fetch the offset bytes, then insert station address
                              res_in.tx_start  = 1'b1;
                              res_in.interrupt = status_ff[ST_TINTEN];
                              tx_ra    = '0;
                              state_in = S_TXH0;
                           end
                        end
                     end else if (a[12:9] == 4'b0010) begin
                        if (a[8:2] != 7'd0) begin
                           res_in.bad_address = 1'b1;
                        end
                     end else if (a[12:9] == 4'b0011) begin
                        if (a[8:3] != 6'd0) begin
                           res_in.bad_address = 1'b1;
                        end else if (!status_ff[ST_AMSW]) begin
                           stn_we = 1'b1;
                           stn_wa = a[2:0];
                           stn_wd = rq.write_data;
                        end
                     end else if (a[12:11] == 2'b01) begin
                        if (!status_ff[ST_TBSW]) begin
                           tx_we = 1'b1;
                           tx_wa = a[BUF_AW-1:0];
                           tx_wd = rq.write_data;
                        end
                     end else if (a[12:11] == 2'b10) begin
                        if (!status_ff[ST_ABSW]) begin
                           rx_we = 1'b1;
                           rx_wa = {1'b0, a[BUF_AW-1:0]};
                           rx_wd = rq.write_data;
                        end
                     end else begin
                        if (!status_ff[ST_BBSW]) begin
                           rx_we = 1'b1;
                           rx_wa = {1'b1, a[BUF_AW-1:0]};
                           rx_wd = rq.write_data;
                        end
                     end
                  end
                  MODE_RX: begin
                     if (tgt_ff == TGT_NONE) begin
                        if (status_ff[ST_AMSW] && status_ff[ST_ABSW]) begin
                           t_new = TGT_A;
                        end else if (status_ff[ST_AMSW] && status_ff[ST_BBSW]) begin
                           t_new = TGT_B;
                        end else begin
                           t_new = TGT_DISCARD;
                        end
                        c_cur = '0;
                        d_cur = '0;
                     end else begin
                        t_new = tgt_ff;
                     end
                     for (int k = 0; k < 6; k++) begin
                        if (c_cur == CNT_W'(k)) begin
                           d_cur[5-k] = rq.rx_byte;
                        end
                     end
                     if (c_cur < CNT_W'(BUFFER_BYTES - 2)) begin
                        if (t_new == TGT_A || t_new == TGT_B) begin
                           rx_we = 1'b1;
                           rx_wa = {t_new == TGT_B, BUF_AW'(c_cur + CNT_W'(2))};
                           rx_wd = rq.rx_byte;
                        end
                        c_cur = c_cur + CNT_W'(1);
                     end
                     tgt_in  = t_new;
                     cnt_in  = c_cur;
                     dest_in = d_cur;
                     if (rq.rx_last) begin
                        // compare destination with the station RAM, one octet a cycle
                        stn_ra   = 3'd0;
                        idx_in   = 3'd0;
                        ours_in  = 1'b1;
                        state_in = S_CMP;
                     end
                  end
                  default: begin
                     tx_ra    = BUF_AW'(rq.fetch_offset);
                     sel_in   = SEL_TX;
                     state_in = S_RD;
                  end
               endcase
            end
         end
         S_RD: begin
            case (sel_ff)
               SEL_STN: res_in.read_data = stn_rd;
               SEL_TX: begin
                  if (item_ff.mode == MODE_FETCH) begin
                     res_in.tx_data = tx_rd;
                  end else begin
                     res_in.read_data = tx_rd;
                  end
               end
               default: res_in.read_data = rx_rd;
            endcase
            state_in = S_DONE;
         end
         S_TXH0: begin
            offhi_in = tx_rd[2:0];
            tx_ra    = BUF_AW'(1);
            state_in = S_TXH1;
         end
         S_TXH1: begin
            off11            = {offhi_ff, tx_rd};
            off_new          = off11[BUF_AW-1:0];
            off_in           = off_new;
            res_in.tx_offset = 11'(off_new);
            res_in.tx_length = 12'(BUFFER_BYTES) - 12'(off_new);
            stn_ra           = 3'd0;
            idx_in           = 3'd0;
            state_in         = S_COPY;
         end
         S_COPY: begin
            tx_we = 1'b1;
            tx_wa = off_ff + BUF_AW'(6) + BUF_AW'(idx_ff);
            tx_wd = stn_rd;
            if (idx_ff == 3'd5) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 3'd1;
               stn_ra = idx_ff + 3'd1;
            end
         end
         S_CMP: begin
            ours_now = ours_ff && (dest_ff[5 - idx_ff] == stn_rd);
            ours_in  = ours_now;
            if (idx_ff != 3'd5) begin
               idx_in = idx_ff + 3'd1;
               stn_ra = idx_ff + 3'd1;
            end else begin
               bcast = (dest_ff == '1);
               hdr   = 16'(cnt_ff) + 16'd2 + 16'(cnt_ff[0]);
               if (!ours_now) begin
                  hdr = hdr | HDR_NOT_OURS;
               end
               if (dest_ff[5][0]) begin
                  if (bcast) begin
                     hdr = hdr | HDR_BROADCAST;
                  end else if (pa < 4'd6) begin
                     drop = 1'b1;
                  end
               end else if (!ours_now && pa > 4'd2) begin
                  drop = 1'b1;
               end
               if (!status_ff[ST_AMSW] || tgt_ff == TGT_NONE || tgt_ff == TGT_DISCARD ||
                   (tgt_ff == TGT_A && !status_ff[ST_ABSW]) ||
                   (tgt_ff == TGT_B && !status_ff[ST_BBSW])) begin
                  drop = 1'b1;
               end
               state_in = S_DONE;
               if (drop) begin
                  res_in.rx_result = RX_DROP;
               end else begin
                  rx_we  = 1'b1;
                  rx_wa  = {tgt_ff == TGT_B, BUF_AW'(0)};
                  rx_wd  = hdr[15:8];
                  off_in = BUF_AW'(hdr[7:0]);
                  state_in = S_HDR;
                  st_tmp = status_ff;
                  if (tgt_ff == TGT_A) begin
                     st_tmp[ST_ABSW]  = 1'b0;
                     st_tmp[ST_RBBA]  = !status_ff[ST_BBSW];
                     res_in.interrupt = status_ff[ST_AINTEN];
                     res_in.rx_result = RX_A;
                  end else begin
                     st_tmp[ST_BBSW]  = 1'b0;
                     st_tmp[ST_RBBA]  = 1'b0;
                     res_in.interrupt = status_ff[ST_BINTEN];
                     res_in.rx_result = RX_B;
                  end
                  status_in = st_tmp;
               end
               tgt_in = TGT_NONE;
               cnt_in = '0;
               dest_in = '0;
            end
         end
         S_HDR: begin
            // low header byte, held in the offset register
            rx_we    = 1'b1;
            rx_wa    = {res_ff.rx_result == RX_B, BUF_AW'(1)};
            rx_wd    = 8'(off_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         status_ff    <= '0;
         rom_ff       <= ROM_RESET;
         tgt_ff       <= TGT_NONE;
         cnt_ff       <= '0;
         dest_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         tgt_ff       <= tgt_in;
         cnt_ff       <= cnt_in;
         dest_ff      <= dest_in;
         if (csr_wr_en) begin
            rom_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= idx_in;
      ours_ff     <= ours_in;
      off_ff      <= off_in;
      offhi_ff    <= offhi_in;
      sel_ff      <= sel_in;
   end
endmodule

/* rtl/ethc_checker.sv */
// Port-level checks of the controller core, bound into the core module.
module ethc_checker import ethc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_tx_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_start |->
         rsp_data.tx_length == 12'(BUFFER_BYTES) - 12'(rsp_data.tx_offset))
      else $error("transmit length does not match offset");

   a_rx_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_result != RX_NONE |->
         !rsp_data.tx_start && !rsp_data.bad_address && rsp_data.read_data == 8'h00)
      else $error("frame result mixed with bus result");
endmodule

bind ethernet_controller_dual_rx_buffer_core ethc_checker u_ethc_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_data(rsp_ch.data)
);
